/* src/int_to_decimal_ascii_core_assert.svh */
// Assertion macros for the integer to decimal text core.
`ifndef INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ITDA_CHECK_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("check failed: label");

// Next-cycle implication, sampled on clk, off during rst.
`define ITDA_CHECK_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("check failed: label");

`endif

/* src/itda_pkg.sv */
// Shared types, constants and the place-value table of the decimal text core.
`timescale 1ns / 1ps

package itda_pkg;

  localparam int VAL_W  = 32;
  localparam int WIDE_W = 36;
  localparam int POS_W  = 4;
  localparam int DIG_W  = 4;
  localparam int CHAR_W = 8;

  localparam logic [POS_W-1:0]  TOP_POS    = 4'd9;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CW    = 2;
  localparam logic [Q_CW-1:0] Q_FULL = Q_CW'(Q_DEPTH);

  typedef struct packed {
    logic             neg;
    logic [VAL_W-1:0] mag;
  } item_t;

  typedef struct packed {
    logic sign_phase;
    logic neg;
  } bk_status_t;

  // 10^pos, widened so that multiples up to nine stay exact
  function automatic logic [WIDE_W-1:0] place_value(logic [POS_W-1:0] pos);
    logic [WIDE_W-1:0] p;
    unique case (pos)
      4'd0:    p = 36'd1;
      4'd1:    p = 36'd10;
      4'd2:    p = 36'd100;
      4'd3:    p = 36'd1000;
      4'd4:    p = 36'd10000;
      4'd5:    p = 36'd100000;
      4'd6:    p = 36'd1000000;
      4'd7:    p = 36'd10000000;
      4'd8:    p = 36'd100000000;
      4'd9:    p = 36'd1000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

/* src/itda_front.sv */
// Front stage: takes a value and splits it into sign and magnitude.
`timescale 1ns / 1ps

module itda_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [itda_pkg::VAL_W-1:0] value,
  output logic                           push_valid,
  input  logic                           push_ready,
  output itda_pkg::item_t                push_item
);

  logic            full;
  itda_pkg::item_t item;
  logic            take;

  assign in_stall   = full && !push_ready;
  assign take       = in_valid && !in_stall;
  assign push_valid = full;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (take) begin
      full <= 1'b1;
    end else if (push_ready) begin
      full <= 1'b0;
    end
  end

  // unsigned negation keeps the most negative value exact
  always_ff @(posedge clk) begin
    if (take) begin
      item.neg <= value[itda_pkg::VAL_W-1];
      item.mag <= value[itda_pkg::VAL_W-1] ? (~value + 1'b1) : value;
    end
  end

endmodule

/* src/itda_queue.sv */
// Short queue between the front and back stages.
`timescale 1ns / 1ps

module itda_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push_valid,
  output logic                      push_ready,
  input  itda_pkg::item_t           push_item,
  output logic                      pop_valid,
  input  logic                      pop_ready,
  output itda_pkg::item_t           pop_item,
  output logic [itda_pkg::Q_CW-1:0] count
);

  itda_pkg::item_t                 mem [itda_pkg::Q_DEPTH];
  logic [itda_pkg::Q_AW-1:0]       wr_ptr;
  logic [itda_pkg::Q_AW-1:0]       rd_ptr;
  logic [itda_pkg::Q_CW-1:0]       count_next;
  logic                            push;
  logic                            pop;

  assign push_ready = count != itda_pkg::Q_FULL;
  assign pop_valid  = count != '0;
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

/* src/itda_back.sv */
// Back stage: one decimal digit per step, most significant first, into an output register.
`timescale 1ns / 1ps

module itda_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  itda_pkg::item_t                   pop_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [itda_pkg::CHAR_W-1:0]       character,
  output logic                              last,
  output itda_pkg::bk_status_t              status
);

  typedef enum logic [2:0] {
    BK_IDLE  = 3'b001,
    BK_SIGN  = 3'b010,
    BK_DIGIT = 3'b100
  } bk_state_t;

  bk_state_t                         state;
  logic                              neg;
  logic [itda_pkg::VAL_W-1:0]        mag;
  logic [itda_pkg::POS_W-1:0]        pos;
  logic                              started;

  logic [itda_pkg::WIDE_W-1:0]       mag_wide;
  logic [itda_pkg::WIDE_W-1:0]       pv;
  logic [itda_pkg::WIDE_W-1:0]       sub;
  logic [itda_pkg::WIDE_W-1:0]       diff;
  logic [itda_pkg::DIG_W-1:0]        dig;
  logic                              out_free;
  logic                              emit;
  logic                              load;

  assign out_free  = !out_valid || !out_stall;
  assign pop_ready = state == BK_IDLE;
  assign mag_wide  = {{(itda_pkg::WIDE_W-itda_pkg::VAL_W){1'b0}}, mag};
  assign pv        = itda_pkg::place_value(pos);

  // nine parallel compares against k * 10^pos; the highest hit is the digit
  always_comb begin
    dig = '0;
    sub = '0;
    for (int k = 1; k <= 9; k++) begin
      if (mag_wide >= pv * itda_pkg::WIDE_W'(k)) begin
        dig = itda_pkg::DIG_W'(k);
        sub = pv * itda_pkg::WIDE_W'(k);
      end
    end
  end

  assign diff = mag_wide - sub;
  // leading zeros are skipped, but the units place always shows
  assign emit = started || (dig != '0) || (pos == '0);
  assign load = out_free && ((state == BK_SIGN) || ((state == BK_DIGIT) && emit));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        BK_IDLE: begin
          if (pop_valid) begin
            neg     <= pop_item.neg;
            mag     <= pop_item.mag;
            pos     <= itda_pkg::TOP_POS;
            started <= 1'b0;
            state   <= pop_item.neg ? BK_SIGN : BK_DIGIT;
          end
        end
        BK_SIGN: begin
          if (out_free) begin
            character <= itda_pkg::CHAR_MINUS;
            last      <= 1'b0;
            state     <= BK_DIGIT;
          end
        end
        BK_DIGIT: begin
          if (!emit || out_free) begin
            mag <= diff[itda_pkg::VAL_W-1:0];
            pos <= pos - 1'b1;
            if (emit) begin
              character <= itda_pkg::CHAR_ZERO + {{(itda_pkg::CHAR_W-itda_pkg::DIG_W){1'b0}}, dig};
              last      <= pos == '0;
              started   <= 1'b1;
            end
            if (pos == '0) state <= BK_IDLE;
          end
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

  assign status.sign_phase = state == BK_SIGN;
  assign status.neg        = neg;

endmodule

/* src/int_to_decimal_ascii_core.sv */
// Top level: signed 32-bit integer to decimal ASCII characters.
//
//   channel | signals                   | payload
//   input   | in_valid / in_stall       | value (32, signed)
//   output  | out_valid / out_stall     | character (8), last (1)
//
// Per value the back stage takes it from the queue, sends a minus sign when negative,
// then makes ten digit steps (leading zeros use a step each but send nothing). The
// single digit-step unit sets the pace: a new value waits until the last is through.
// Front register and two-entry queue let values gather while the back works.
// rst is synchronous; afterwards queue and output register are empty.
// A stalled output holds its character; the steps that send a character wait for it.
`timescale 1ns / 1ps
`include "int_to_decimal_ascii_core_assert.svh"

module int_to_decimal_ascii_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [itda_pkg::VAL_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [itda_pkg::CHAR_W-1:0]       character,
  output logic                              last
);

  logic                        push_valid;
  logic                        push_ready;
  itda_pkg::item_t             push_item;
  logic                        pop_valid;
  logic                        pop_ready;
  itda_pkg::item_t             pop_item;
  logic [itda_pkg::Q_CW-1:0]   q_count;
  itda_pkg::bk_status_t        bk_status;

  itda_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  itda_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .count      (q_count)
  );

  itda_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .character  (character),
    .last       (last),
    .status     (bk_status)
  );

  `ITDA_CHECK_NOW(a_queue_bound, 1'b1, q_count <= itda_pkg::Q_FULL)
  `ITDA_CHECK_NOW(a_sign_not_last, out_valid && character == itda_pkg::CHAR_MINUS, !last)
  `ITDA_CHECK_NOW(a_sign_only_neg, bk_status.sign_phase, bk_status.neg)
  `ITDA_CHECK_NEXT(a_sign_leaves_char, bk_status.sign_phase, out_valid || bk_status.sign_phase)

endmodule

/* verif/itda_checker.sv */
// Checker for the decimal text core: predicts each value's characters and compares transfers.
`timescale 1ns / 1ps

module itda_text_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [itda_pkg::VAL_W-1:0]  value,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [itda_pkg::CHAR_W-1:0] character,
  input  logic                        last,
  output int                          failures,
  output int                          waiting,
  output int                          chars_seen
);

  localparam int MAX_DIGITS = 10;

  typedef struct packed {
    logic [itda_pkg::CHAR_W-1:0] ch;
    logic                        fin;
  } glyph_t;

  glyph_t awaited_text[$];

  task automatic report_mismatch(input string what);
    failures++;
    $display("%0t ns  mismatch: %s", $time, what);
  endtask

  // queue up the characters one value turns into, sign first
  function automatic void spell_decimal(input logic [itda_pkg::VAL_W-1:0] raw);
    logic [itda_pkg::VAL_W-1:0] mag;
    logic [itda_pkg::DIG_W-1:0] digs [MAX_DIGITS];
    int                         count;
    glyph_t                     g;
    mag   = raw[itda_pkg::VAL_W-1] ? (itda_pkg::VAL_W'(0) - raw) : raw;
    count = 0;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (k == 0 || mag != '0) begin
        digs[k] = itda_pkg::DIG_W'(mag % 32'd10);
        mag     = mag / 32'd10;
        count   = k + 1;
      end
    end
    if (raw[itda_pkg::VAL_W-1]) begin
      g.ch  = itda_pkg::CHAR_MINUS;
      g.fin = 1'b0;
      awaited_text.push_back(g);
    end
    for (int k = count - 1; k >= 0; k--) begin
      g.ch  = itda_pkg::CHAR_ZERO + itda_pkg::CHAR_W'(digs[k]);
      g.fin = (k == 0);
      awaited_text.push_back(g);
    end
  endfunction

  always @(posedge clk) begin : watch
    glyph_t want;
    if (rst) begin
      awaited_text.delete();
    end else begin
      if (out_valid && !out_stall) begin
        chars_seen++;
        if (awaited_text.size() == 0) begin
          report_mismatch($sformatf("character 8'h%02h with nothing awaited", character));
        end else begin
          want = awaited_text.pop_front();
          if (character !== want.ch) begin
            report_mismatch($sformatf("character 8'h%02h, awaited 8'h%02h",
                                      character, want.ch));
          end
          if (last !== want.fin) begin
            report_mismatch($sformatf("last %b, awaited %b on character 8'h%02h",
                                      last, want.fin, want.ch));
          end
        end
      end
      if (in_valid && !in_stall) begin
        spell_decimal(value);
      end
    end
    waiting = awaited_text.size();
  end

endmodule

/* verif/tb.sv */
// Testbench top: drives values with random gaps, stalls the text output, gives the verdict.
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT    = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_VALUES = 430;
  localparam int DRAIN_CYCLES  = 40;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              in_valid;
  logic                              in_stall;
  logic signed [itda_pkg::VAL_W-1:0] value;
  logic                              out_valid;
  logic                              out_stall;
  logic [itda_pkg::CHAR_W-1:0]       character;
  logic                              last;

  int failures;
  int waiting;
  int chars_seen;
  int sent;
  int negatives;
  int blocked_offers;
  int idle_cycles;

  bit steady;     // no gaps on either side
  bit eager;      // no gaps on the input side only
  bit hold_long;  // request for the long output hold-off

  int corner_values [22] = '{
    0, 1, -1, 5, -5, 9, 10, -10, 99, 100, -100, 999999999, -999999999,
    1000000000, -1000000000, 1999999999, 123456789, -987654321,
    2147483647, -2147483647, -2147483647 - 1, 1000000
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int_to_decimal_ascii_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

  itda_text_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .character  (character),
    .last       (last),
    .failures   (failures),
    .waiting    (waiting),
    .chars_seen (chars_seen)
  );

  // mostly none or short, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // full-range words, or a chosen digit count with its boundaries favoured
  function automatic logic [itda_pkg::VAL_W-1:0] pick_value();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mag;
    int              nd;
    if ($urandom_range(0, 9) < 3) return $urandom();
    nd = $urandom_range(1, 10);
    lo = 1;
    for (int k = 1; k < nd; k++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (nd == 1) lo = 0;
    if (hi > 64'd2147483648) hi = 64'd2147483648;
    if ($urandom_range(0, 3) == 0) begin
      mag = $urandom_range(0, 1) ? lo : hi;
    end else begin
      mag = lo + $urandom_range(0, 32'(hi - lo));
    end
    if ($urandom_range(0, 1)) return itda_pkg::VAL_W'(64'd0 - mag);
    if (mag > 64'd2147483647) mag = 64'd2147483647;
    return itda_pkg::VAL_W'(mag);
  endfunction

  // called just after a falling edge; returns just after the falling edge past the transfer
  task automatic offer_value(input logic [itda_pkg::VAL_W-1:0] v);
    int gap;
    gap = (steady || eager) ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
    if (v[itda_pkg::VAL_W-1]) negatives++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && in_stall) blocked_offers <= blocked_offers + 1;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("no transfer for %0d cycles, %0d characters still awaited",
                 IDLE_LIMIT, waiting);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : text_sink
    int len;
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_long && !held) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end else begin
        len = steady ? 0 : idle_length();
        if (len > 0) begin
          out_stall <= 1'b1;
          repeat (len) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat (steady ? 4 : $urandom_range(1, 8)) @(negedge clk);
    end
  end

  initial begin : stimulus
    rst       = 1'b1;
    in_valid  = 1'b0;
    value     = '0;
    steady    = 1'b0;
    eager     = 1'b0;
    hold_long = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (corner_values[i]) offer_value(corner_values[i]);

    for (int i = 0; i < RANDOM_VALUES; i++) begin
      steady = (i >= 100 && i < 160);
      eager  = (i >= 200 && i < 240);
      // output held off while the input keeps offering, so the queue fills
      if (i == 200) hold_long = 1'b1;
      offer_value(pick_value());
    end
    in_valid <= 1'b0;

    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d values (%0d negative, corners incl. zero and both extremes)",
             sent, negatives);
    $display("into %0d characters; gaps, no-gap runs, %0d-cycle hold-off, %0d blocked offers",
             chars_seen, HOLD_CYCLES, blocked_offers);
    if (failures == 0 && waiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
